// ----- rtl/tpbc_pkg.sv -----
// Shared types, codes and constants of the token passing bus controller.
`timescale 1ns / 1ps
`default_nettype none
package tpbc_pkg;

  localparam int NODE_SLOTS_DEF = 256;
  localparam int ROUND_COUNTER_BITS_DEF = 16;

  localparam int TICKET_W = 16;
  localparam int DIV_W = 8;
  localparam int ID_W = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int ROUNDS_W = 16;

  localparam logic [ID_W-1:0] NONE_ID = 8'd255;

  localparam logic ROLE_MASTER_DEF = 1'b0;
  localparam logic [ROUNDS_W-1:0] CONNECT_ROUNDS_DEF = 16'd40;
  localparam logic [ROUNDS_W-1:0] TIMEOUT_ROUNDS_DEF = 16'd40;
  localparam logic [DIV_W-1:0] ATTEMPT_DIVISOR_DEF = 8'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROLE_MASTER = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONNECT_ROUNDS = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_ROUNDS = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATTEMPT_DIVISOR = 8'd3;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MSG = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [1:0] KIND_ACCEPTING = 2'd0;
  localparam logic [1:0] KIND_CONN_REQ = 2'd1;
  localparam logic [1:0] KIND_TOKEN_IN = 2'd2;
  localparam logic [1:0] KIND_TOKEN_OUT = 2'd3;

  typedef enum logic [2:0] {
    PH_UNJAM = 3'd0,
    PH_OFFER = 3'd1,
    PH_AWAIT = 3'd2,
    PH_OWN   = 3'd3,
    PH_TIN   = 3'd4,
    PH_TOUT  = 3'd5
  } tpbc_phase_e;

  typedef enum logic [3:0] {
    C_IDLE   = 4'b0001,
    C_SEARCH = 4'b0010,
    C_DIVIDE = 4'b0100,
    C_EMIT   = 4'b1000
  } tpbc_ctrl_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [1:0]          msg_kind;
    logic [ID_W-1:0]     msg_source;
    logic [TICKET_W-1:0] ticket;
  } tpbc_in_t;

  typedef struct packed {
    logic            send_valid;
    logic            send_broadcast;
    logic [ID_W-1:0] send_dest;
    logic [1:0]      send_kind;
    logic            unjam_pulse;
    logic            send_opportunity;
    logic [2:0]      node_state;
    logic            connected;
    logic [ID_W-1:0] master_id;
    logic            removed_valid;
  } tpbc_out_t;

  typedef struct packed {
    logic done;
    logic zero;
  } tpbc_mod_res_t;

endpackage
`default_nettype wire

// ----- rtl/token_passing_bus_controller_unit.sv -----
// Top level of the token passing bus controller: sequencer, node state and slot search.
//
// Usage: one item on the input channel is one event (tick, received message or
// protocol reset); each item gives exactly one result item on the output channel.
// Both channels use valid/ready. The configuration channel is always ready and
// writes role, connect rounds, timeout rounds and attempt divisor by index;
// unknown indexes are dropped. Write it only while the block is idle.
// An ordinary item goes from the idle step straight to the emit step, where its
// result is loaded once the output register is free. A slave offer while
// disconnected first runs the remainder unit, one ticket bit per cycle. A master
// tick in the token in phase first walks the membership RAM one slot per cycle
// from the last grantee up, pipelined over its registered read port.
// The input is not ready while an item is in work; the next item is taken
// the cycle after the result is loaded, while that result may still wait in
// the output register. Reset leaves a slave node, disconnected, master in unjam,
// all membership valid bits cleared and default register values. A stalled
// receiver holds the result; the sequencer then waits in its final step.
`timescale 1ns / 1ps
`default_nettype none
module token_passing_bus_controller_unit #(
  parameter int NODE_SLOTS = tpbc_pkg::NODE_SLOTS_DEF,
  parameter int ROUND_COUNTER_BITS = tpbc_pkg::ROUND_COUNTER_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire tpbc_pkg::tpbc_in_t               in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output tpbc_pkg::tpbc_out_t                   out_item_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tpbc_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [tpbc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int SLOT_BITS = $clog2(NODE_SLOTS);
  localparam int PTR_W = SLOT_BITS + 1;
  localparam int RCB = ROUND_COUNTER_BITS;
  localparam int CMP_W = (RCB > tpbc_pkg::ROUNDS_W) ? RCB : tpbc_pkg::ROUNDS_W;

  tpbc_pkg::tpbc_ctrl_e ctrl_q, ctrl_d;

  logic                          role_q;
  logic [tpbc_pkg::ROUNDS_W-1:0] conn_rounds_q;
  logic [tpbc_pkg::ROUNDS_W-1:0] tmo_rounds_q;
  logic [tpbc_pkg::DIV_W-1:0]    att_div_q;

  tpbc_pkg::tpbc_phase_e        ph_q, ph_d;
  logic                         linked_q, linked_d;
  logic [RCB-1:0]               rounds_q, rounds_d, rounds_inc;
  logic [tpbc_pkg::ID_W-1:0]    lg_q, lg_d;
  logic [tpbc_pkg::ID_W-1:0]    km_q, km_d;
  logic [NODE_SLOTS-1:0]        valid_q, valid_d;

  tpbc_pkg::tpbc_in_t           item_q;
  tpbc_pkg::tpbc_out_t          out_q, res;
  logic                         out_valid_q, out_valid_d;

  logic [PTR_W-1:0]             ptr_q, ptr_d;
  logic                         pend_q, pend_d;
  logic [SLOT_BITS-1:0]         pend_idx_q;
  logic                         vbit_q;
  logic [tpbc_pkg::ID_W-1:0]    found_q, found_d;
  logic                         hit_q, hit_d;
  logic                         zero_q, zero_d;

  logic                         accept, commit, ptr_live, hit_now, issue;
  logic                         want_search, want_div, changed;
  logic [8:0]                   start9;
  logic                         bm_we, bm_wdata, bm_rdata;
  logic [SLOT_BITS-1:0]         bm_waddr;
  tpbc_pkg::tpbc_mod_res_t      mod_res;

  assign in_ready_o  = (ctrl_q == tpbc_pkg::C_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign commit      = (ctrl_q == tpbc_pkg::C_EMIT) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q        <= tpbc_pkg::ROLE_MASTER_DEF;
      conn_rounds_q <= tpbc_pkg::CONNECT_ROUNDS_DEF;
      tmo_rounds_q  <= tpbc_pkg::TIMEOUT_ROUNDS_DEF;
      att_div_q     <= tpbc_pkg::ATTEMPT_DIVISOR_DEF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tpbc_pkg::CFG_ROLE_MASTER:     role_q        <= cfg_data_i[0];
        tpbc_pkg::CFG_CONNECT_ROUNDS:  conn_rounds_q <= cfg_data_i;
        tpbc_pkg::CFG_TIMEOUT_ROUNDS:  tmo_rounds_q  <= cfg_data_i;
        tpbc_pkg::CFG_ATTEMPT_DIVISOR: att_div_q     <= cfg_data_i[tpbc_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  assign want_search = role_q && (in_item_i.operation == tpbc_pkg::OP_TICK) &&
                       (ph_q == tpbc_pkg::PH_TIN);
  assign want_div    = !role_q && (in_item_i.operation == tpbc_pkg::OP_MSG) &&
                       (in_item_i.msg_kind == tpbc_pkg::KIND_ACCEPTING) && !linked_q;
  assign start9      = (lg_q == tpbc_pkg::NONE_ID) ? 9'd0 : {1'b0, lg_q} + 9'd1;
  assign ptr_live    = (ptr_q < PTR_W'(NODE_SLOTS));
  assign hit_now     = pend_q && bm_rdata && vbit_q;
  assign issue       = (ctrl_q == tpbc_pkg::C_SEARCH) && ptr_live && !hit_now;

  tpbc_mod_unit u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && want_div),
    .ticket_i (in_item_i.ticket),
    .divisor_i(att_div_q),
    .res_o    (mod_res)
  );

  tpbc_ram #(
    .WIDTH(1),
    .DEPTH(NODE_SLOTS)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (commit && bm_we),
    .waddr_i(bm_waddr),
    .wdata_i(bm_wdata),
    .raddr_i(ptr_q[SLOT_BITS-1:0]),
    .rdata_o(bm_rdata)
  );

  always_comb begin
    ctrl_d  = ctrl_q;
    ptr_d   = ptr_q;
    pend_d  = 1'b0;
    found_d = found_q;
    hit_d   = hit_q;
    zero_d  = zero_q;
    case (ctrl_q)
      tpbc_pkg::C_IDLE: begin
        if (accept) begin
          hit_d = 1'b0;
          ptr_d = (start9 >= 9'(NODE_SLOTS)) ? PTR_W'(NODE_SLOTS) : start9[PTR_W-1:0];
          if (want_search) begin
            ctrl_d = tpbc_pkg::C_SEARCH;
          end else if (want_div) begin
            ctrl_d = tpbc_pkg::C_DIVIDE;
          end else begin
            ctrl_d = tpbc_pkg::C_EMIT;
          end
        end
      end
      tpbc_pkg::C_SEARCH: begin
        pend_d = issue;
        if (issue) begin
          ptr_d = ptr_q + 1'b1;
        end
        if (hit_now) begin
          hit_d   = 1'b1;
          found_d = tpbc_pkg::ID_W'(pend_idx_q);
          ctrl_d  = tpbc_pkg::C_EMIT;
        end else if (!ptr_live) begin
          ctrl_d = tpbc_pkg::C_EMIT;
        end
      end
      tpbc_pkg::C_DIVIDE: begin
        if (mod_res.done) begin
          zero_d = mod_res.zero;
          ctrl_d = tpbc_pkg::C_EMIT;
        end
      end
      tpbc_pkg::C_EMIT: begin
        if (commit) begin
          ctrl_d = tpbc_pkg::C_IDLE;
        end
      end
      default: ctrl_d = tpbc_pkg::C_IDLE;
    endcase
  end

  assign rounds_inc = (rounds_q == '1) ? rounds_q : rounds_q + 1'b1;

  always_comb begin
    ph_d     = ph_q;
    linked_d = linked_q;
    rounds_d = rounds_q;
    lg_d     = lg_q;
    km_d     = km_q;
    bm_we    = 1'b0;
    bm_waddr = '0;
    bm_wdata = 1'b0;
    res      = '0;
    changed  = 1'b0;
    case (item_q.operation)
      tpbc_pkg::OP_TICK: begin
        if (role_q) begin
          case (ph_q)
            tpbc_pkg::PH_UNJAM: begin
              res.unjam_pulse = 1'b1;
              ph_d = tpbc_pkg::PH_OFFER;
            end
            tpbc_pkg::PH_OFFER: begin
              res.send_valid     = 1'b1;
              res.send_broadcast = 1'b1;
              res.send_kind      = tpbc_pkg::KIND_ACCEPTING;
              ph_d = tpbc_pkg::PH_AWAIT;
            end
            tpbc_pkg::PH_AWAIT: begin
              if (CMP_W'(rounds_inc) >= CMP_W'(conn_rounds_q)) begin
                ph_d = tpbc_pkg::PH_OWN;
              end
            end
            tpbc_pkg::PH_OWN: begin
              res.send_opportunity = 1'b1;
              lg_d = tpbc_pkg::NONE_ID;
              ph_d = tpbc_pkg::PH_TIN;
            end
            tpbc_pkg::PH_TOUT: begin
              if (CMP_W'(rounds_inc) >= CMP_W'(tmo_rounds_q)) begin
                if ({1'b0, lg_q} < 9'(NODE_SLOTS)) begin
                  bm_we    = 1'b1;
                  bm_waddr = lg_q[SLOT_BITS-1:0];
                  bm_wdata = 1'b0;
                end
                res.removed_valid = 1'b1;
                ph_d = tpbc_pkg::PH_UNJAM;
              end
            end
            tpbc_pkg::PH_TIN: begin
              if (hit_q) begin
                lg_d          = found_q;
                res.send_valid = 1'b1;
                res.send_dest  = found_q;
                res.send_kind  = tpbc_pkg::KIND_TOKEN_IN;
                ph_d = tpbc_pkg::PH_TOUT;
              end else begin
                ph_d = tpbc_pkg::PH_UNJAM;
              end
            end
            default: ;
          endcase
          changed = (ph_d != ph_q);
        end else begin
          if (linked_q && (CMP_W'(rounds_inc) >= CMP_W'(tmo_rounds_q))) begin
            linked_d = 1'b0;
          end
          changed = (linked_d != linked_q);
        end
        rounds_d = changed ? '0 : rounds_inc;
      end
      tpbc_pkg::OP_MSG: begin
        if (role_q) begin
          if (item_q.msg_kind == tpbc_pkg::KIND_CONN_REQ) begin
            if ({1'b0, item_q.msg_source} < 9'(NODE_SLOTS)) begin
              bm_we    = 1'b1;
              bm_waddr = item_q.msg_source[SLOT_BITS-1:0];
              bm_wdata = 1'b1;
            end
          end else if (item_q.msg_kind == tpbc_pkg::KIND_TOKEN_OUT) begin
            ph_d = tpbc_pkg::PH_TIN;
          end
        end else begin
          if ((item_q.msg_kind == tpbc_pkg::KIND_ACCEPTING) && !linked_q) begin
            if (zero_q) begin
              res.send_valid = 1'b1;
              res.send_dest  = item_q.msg_source;
              res.send_kind  = tpbc_pkg::KIND_CONN_REQ;
            end
          end else if (item_q.msg_kind == tpbc_pkg::KIND_TOKEN_IN) begin
            if (!linked_q) begin
              km_d     = item_q.msg_source;
              linked_d = 1'b1;
            end
            rounds_d             = '0;
            res.send_opportunity = 1'b1;
            res.send_valid       = 1'b1;
            res.send_dest        = item_q.msg_source;
            res.send_kind        = tpbc_pkg::KIND_TOKEN_OUT;
          end
        end
      end
      tpbc_pkg::OP_RESET: begin
        if (role_q) begin
          ph_d = tpbc_pkg::PH_UNJAM;
        end else begin
          linked_d = 1'b0;
        end
      end
      default: ;
    endcase
    res.node_state = role_q ? ph_d : {2'b00, linked_d};
    res.connected  = role_q ? 1'b1 : linked_d;
    res.master_id  = km_d;
  end

  always_comb begin
    valid_d = valid_q;
    if (commit && bm_we) begin
      valid_d[bm_waddr] = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= tpbc_pkg::C_IDLE;
      ph_q        <= tpbc_pkg::PH_UNJAM;
      linked_q    <= 1'b0;
      rounds_q    <= '0;
      lg_q        <= tpbc_pkg::NONE_ID;
      km_q        <= tpbc_pkg::NONE_ID;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      ctrl_q      <= ctrl_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (commit) begin
        ph_q     <= ph_d;
        linked_q <= linked_d;
        rounds_q <= rounds_d;
        lg_q     <= lg_d;
        km_q     <= km_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (commit) begin
      out_q <= res;
    end
    ptr_q      <= ptr_d;
    found_q    <= found_d;
    hit_q      <= hit_d;
    zero_q     <= zero_d;
    pend_idx_q <= ptr_q[SLOT_BITS-1:0];
    vbit_q     <= valid_q[ptr_q[SLOT_BITS-1:0]];
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready while an item is in work");

  a_rounds_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(rounds_q))
    else $error("round counter moved outside a commit");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q == tpbc_pkg::C_SEARCH) |-> (ptr_q <= PTR_W'(NODE_SLOTS)))
    else $error("search pointer beyond slot range");

  a_emit_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q == tpbc_pkg::C_DIVIDE && mod_res.done) |=> (ctrl_q == tpbc_pkg::C_EMIT))
    else $error("remainder result not taken");
`endif

endmodule
`default_nettype wire

// ----- rtl/tpbc_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tpbc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/tpbc_mod_unit.sv -----
// Bit-serial remainder unit for the slave connection ticket test.
`timescale 1ns / 1ps
`default_nettype none
module tpbc_mod_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tpbc_pkg::TICKET_W-1:0] ticket_i,
  input  wire logic [tpbc_pkg::DIV_W-1:0]    divisor_i,
  output tpbc_pkg::tpbc_mod_res_t            res_o
);

  localparam int STEP_W = $clog2(tpbc_pkg::TICKET_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic                          zero_q, zero_d;
  logic [STEP_W-1:0]             cnt_q, cnt_d;
  logic [tpbc_pkg::TICKET_W-1:0] sh_q, sh_d;
  logic [tpbc_pkg::DIV_W-1:0]    rem_q, rem_d;
  logic [tpbc_pkg::DIV_W-1:0]    div_q, div_d;
  logic [tpbc_pkg::DIV_W:0]      trial;
  logic [tpbc_pkg::DIV_W:0]      rem_next;

  always_comb begin
    trial    = {rem_q, sh_q[tpbc_pkg::TICKET_W-1]};
    rem_next = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
    busy_d   = busy_q;
    done_d   = 1'b0;
    zero_d   = zero_q;
    cnt_d    = cnt_q;
    sh_d     = sh_q;
    rem_d    = rem_q;
    div_d    = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = ticket_i;
      rem_d  = '0;
      div_d  = (divisor_i == '0) ? tpbc_pkg::DIV_W'(1) : divisor_i;
    end else if (busy_q) begin
      sh_d  = {sh_q[tpbc_pkg::TICKET_W-2:0], 1'b0};
      rem_d = rem_next[tpbc_pkg::DIV_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_W'(tpbc_pkg::TICKET_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        zero_d = (rem_next == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign res_o.done = done_q;
  assign res_o.zero = zero_q;

endmodule
`default_nettype wire

// ----- tb/token_passing_bus_controller_unit_tb.sv -----
// Self-checking testbench of the token passing bus controller unit, with directed and random items.
`timescale 1ns / 1ps
module token_passing_bus_controller_unit_tb;
  import tpbc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int END_SETTLE = 300;
  localparam int MAX_REPORTS = 40;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = 8'd4;
  localparam logic [ROUNDS_W-1:0] ROUND_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tpbc_in_t in_item = '0;
  logic out_valid;
  logic sink_ready = 1'b0;
  tpbc_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic node_role;
  logic [ROUNDS_W-1:0] cfg_connect;
  logic [ROUNDS_W-1:0] cfg_timeout;
  logic [DIV_W-1:0] cfg_divisor;
  tpbc_phase_e phase_q;
  logic slave_up;
  logic [ROUNDS_W-1:0] round_count;
  logic [NODE_SLOTS_DEF-1:0] members;
  logic [ID_W-1:0] grantee;
  logic [ID_W-1:0] seen_master;

  tpbc_out_t due_responses[$];
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int sink_wait = 0;
  bit sink_hold_req = 1'b0;
  bit quiet_stretch = 1'b0;

  token_passing_bus_controller_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(sink_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void reset_node();
    node_role = 1'b0;
    cfg_connect = CONNECT_ROUNDS_DEF;
    cfg_timeout = TIMEOUT_ROUNDS_DEF;
    cfg_divisor = ATTEMPT_DIVISOR_DEF;
    phase_q = PH_UNJAM;
    slave_up = 1'b0;
    round_count = '0;
    members = '0;
    grantee = NONE_ID;
    seen_master = NONE_ID;
  endfunction

  function automatic void load_register(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ROLE_MASTER:     node_role = data[0];
      CFG_CONNECT_ROUNDS:  cfg_connect = data;
      CFG_TIMEOUT_ROUNDS:  cfg_timeout = data;
      CFG_ATTEMPT_DIVISOR: cfg_divisor = data[DIV_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] node_code();
    return node_role ? logic'(1'b0) | phase_q : {2'b00, slave_up};
  endfunction

  function automatic tpbc_out_t node_response(tpbc_in_t item);
    tpbc_out_t r;
    logic [2:0] prior;
    logic [DIV_W-1:0] d;
    logic found;
    logic [ID_W-1:0] next_id;
    int start;
    r = '0;
    next_id = '0;
    if (item.operation == OP_TICK) begin
      prior = node_code();
      if (round_count != ROUND_MAX) round_count++;
      if (node_role) begin
        case (phase_q)
          PH_UNJAM: begin
            r.unjam_pulse = 1'b1;
            phase_q = PH_OFFER;
          end
          PH_OFFER: begin
            r.send_valid = 1'b1;
            r.send_broadcast = 1'b1;
            r.send_kind = KIND_ACCEPTING;
            phase_q = PH_AWAIT;
          end
          PH_AWAIT: if (round_count >= cfg_connect) phase_q = PH_OWN;
          PH_OWN: begin
            r.send_opportunity = 1'b1;
            grantee = NONE_ID;
            phase_q = PH_TIN;
          end
          PH_TOUT: begin
            if (round_count >= cfg_timeout) begin
              members[grantee] = 1'b0;
              r.removed_valid = 1'b1;
              phase_q = PH_UNJAM;
            end
          end
          PH_TIN: begin
            start = (grantee == NONE_ID) ? 0 : int'(grantee) + 1;
            found = 1'b0;
            for (int i = 0; i < NODE_SLOTS_DEF; i++) begin
              if (!found && i >= start && members[i]) begin
                found = 1'b1;
                next_id = 8'(i);
              end
            end
            if (found) begin
              grantee = next_id;
              r.send_valid = 1'b1;
              r.send_dest = next_id;
              r.send_kind = KIND_TOKEN_IN;
              phase_q = PH_TOUT;
            end else begin
              phase_q = PH_UNJAM;
            end
          end
          default: ;
        endcase
      end else if (slave_up && round_count >= cfg_timeout) begin
        slave_up = 1'b0;
      end
      if (node_code() != prior) round_count = '0;
    end else if (item.operation == OP_MSG) begin
      if (node_role) begin
        if (item.msg_kind == KIND_CONN_REQ) begin
          members[item.msg_source] = 1'b1;
        end else if (item.msg_kind == KIND_TOKEN_OUT) begin
          phase_q = PH_TIN;
        end
      end else if (item.msg_kind == KIND_ACCEPTING && !slave_up) begin
        d = (cfg_divisor == '0) ? 8'd1 : cfg_divisor;
        if (item.ticket % d == 0) begin
          r.send_valid = 1'b1;
          r.send_dest = item.msg_source;
          r.send_kind = KIND_CONN_REQ;
        end
      end else if (item.msg_kind == KIND_TOKEN_IN) begin
        if (!slave_up) begin
          seen_master = item.msg_source;
          slave_up = 1'b1;
        end
        round_count = '0;
        r.send_opportunity = 1'b1;
        r.send_valid = 1'b1;
        r.send_dest = item.msg_source;
        r.send_kind = KIND_TOKEN_OUT;
      end
    end else if (item.operation == OP_RESET) begin
      if (node_role) phase_q = PH_UNJAM;
      else slave_up = 1'b0;
    end
    r.node_state = node_code();
    r.connected = node_role ? 1'b1 : slave_up;
    r.master_id = seen_master;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
    end
  endtask

  task automatic check_result(tpbc_out_t got);
    tpbc_out_t want;
    results_seen++;
    if (due_responses.size() == 0) begin
      report_mismatch("item with nothing expected", 0, 0);
    end else begin
      want = due_responses.pop_front();
      if (got.send_valid !== want.send_valid)
        report_mismatch("send_valid", got.send_valid, want.send_valid);
      if (got.send_broadcast !== want.send_broadcast)
        report_mismatch("send_broadcast", got.send_broadcast, want.send_broadcast);
      if (got.send_dest !== want.send_dest)
        report_mismatch("send_dest", got.send_dest, want.send_dest);
      if (got.send_kind !== want.send_kind)
        report_mismatch("send_kind", got.send_kind, want.send_kind);
      if (got.unjam_pulse !== want.unjam_pulse)
        report_mismatch("unjam_pulse", got.unjam_pulse, want.unjam_pulse);
      if (got.send_opportunity !== want.send_opportunity)
        report_mismatch("send_opportunity", got.send_opportunity, want.send_opportunity);
      if (got.node_state !== want.node_state)
        report_mismatch("node_state", got.node_state, want.node_state);
      if (got.connected !== want.connected)
        report_mismatch("connected", got.connected, want.connected);
      if (got.master_id !== want.master_id)
        report_mismatch("master_id", got.master_id, want.master_id);
      if (got.removed_valid !== want.removed_valid)
        report_mismatch("removed_valid", got.removed_valid, want.removed_valid);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && sink_ready) begin
        check_result(out_item);
        sink_wait = quiet_stretch ? 0 : $urandom_range(11, 0);
      end
      if (sink_hold_req) begin
        sink_wait = SINK_HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end
    end
    if (sink_wait > 0) begin
      sink_ready <= 1'b0;
      sink_wait--;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  task automatic send_event(logic [1:0] op, logic [1:0] kind, logic [ID_W-1:0] src,
                            logic [TICKET_W-1:0] tkt);
    tpbc_in_t item;
    int gap;
    item = '{operation: op, msg_kind: kind, msg_source: src, ticket: tkt};
    gap = quiet_stretch ? 0 : $urandom_range(11, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    due_responses.push_back(node_response(item));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(logic role_sel, logic [ROUNDS_W-1:0] connect,
                                logic [ROUNDS_W-1:0] timeout, logic [DIV_W-1:0] divisor);
    logic [CFG_INDEX_W-1:0] idx [5];
    logic [CFG_DATA_W-1:0] dat [5];
    wait_idle();
    idx = '{8'($urandom_range(255, CFG_FIRST_UNUSED)), CFG_ROLE_MASTER, CFG_CONNECT_ROUNDS,
            CFG_TIMEOUT_ROUNDS, CFG_ATTEMPT_DIVISOR};
    dat = '{16'($urandom), {15'($urandom), role_sel}, connect, timeout,
            {8'($urandom), divisor}};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= dat[k];
      do @(posedge clk); while (!cfg_ready);
      load_register(idx[k], dat[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_slave_directed();
    send_event(OP_MSG, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_MSG, KIND_ACCEPTING, 8'd254, 16'hFFFE);
    send_event(OP_MSG, KIND_TOKEN_IN, 8'd200, 16'd0);
    send_event(OP_MSG, KIND_TOKEN_IN, 8'd254, 16'hFFFF);
    send_event(OP_MSG, KIND_ACCEPTING, 8'd3, 16'd0);
    send_event(OP_MSG, KIND_CONN_REQ, 8'd255, 16'd0);
    send_event(OP_MSG, KIND_TOKEN_OUT, 8'd0, 16'd0);
    send_event(OP_TICK, KIND_TOKEN_OUT, 8'hFF, 16'hFFFF);
    send_event(OP_RESET, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_SPARE, KIND_TOKEN_OUT, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_master_directed();
    apply_settings(1'b1, 16'd1, 16'd1, ATTEMPT_DIVISOR_DEF);
    send_event(OP_TICK, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_TICK, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_MSG, KIND_CONN_REQ, 8'd0, 16'd0);
    send_event(OP_MSG, KIND_CONN_REQ, 8'd254, 16'd0);
    send_event(OP_MSG, KIND_CONN_REQ, 8'd255, 16'd0);
    send_event(OP_MSG, KIND_ACCEPTING, 8'd9, 16'd0);
    send_event(OP_MSG, KIND_TOKEN_IN, 8'd9, 16'd0);
    send_event(OP_TICK, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_TICK, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_TICK, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_MSG, KIND_TOKEN_OUT, 8'd0, 16'd0);
    send_event(OP_TICK, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_TICK, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_MSG, KIND_TOKEN_OUT, 8'd254, 16'd0);
    send_event(OP_TICK, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_TICK, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_MSG, KIND_TOKEN_OUT, 8'd255, 16'd0);
    send_event(OP_TICK, KIND_ACCEPTING, 8'd0, 16'd0);
    send_event(OP_RESET, KIND_TOKEN_OUT, 8'd0, 16'd0);
    send_event(OP_SPARE, KIND_ACCEPTING, 8'd0, 16'd0);
  endtask

  task automatic test_register_extremes();
    apply_settings(1'b0, CONNECT_ROUNDS_DEF, 16'd1, 8'd0);
    send_event(OP_MSG, KIND_ACCEPTING, 8'd9, 16'($urandom));
    send_event(OP_MSG, KIND_TOKEN_IN, 8'd9, 16'($urandom));
    send_event(OP_TICK, KIND_ACCEPTING, 8'd9, 16'($urandom));
    send_event(OP_MSG, KIND_ACCEPTING, 8'd9, 16'($urandom));
    apply_settings(1'b1, ROUND_MAX, ROUND_MAX, 8'd255);
    for (int k = 0; k < 12; k++) begin
      if (k == 5) send_event(OP_MSG, KIND_CONN_REQ, 8'($urandom_range(40, 0)), 16'($urandom));
      else if (k == 6) send_event(OP_MSG, KIND_TOKEN_OUT, 8'($urandom), 16'($urandom));
      else send_event(OP_TICK, 2'($urandom), 8'($urandom), 16'($urandom));
    end
    apply_settings(1'b0, 16'd1, ROUND_MAX, 8'd255);
    send_event(OP_MSG, KIND_ACCEPTING, 8'd1, 16'd0);
    send_event(OP_MSG, KIND_ACCEPTING, 8'd2, 16'd255);
    send_event(OP_MSG, KIND_ACCEPTING, 8'd3, 16'd510);
    send_event(OP_MSG, KIND_ACCEPTING, 8'd4, 16'($urandom));
    send_event(OP_MSG, KIND_TOKEN_IN, 8'($urandom), 16'($urandom));
    repeat (3) send_event(OP_TICK, 2'($urandom), 8'($urandom), 16'($urandom));
    apply_settings(1'b1, 16'd1, 16'd1, 8'd1);
    repeat (12) send_event(2'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic test_master_rounds();
    int pick;
    for (int chunk = 0; chunk < 4; chunk++) begin
      apply_settings(1'b1, 16'($urandom_range(4, 1)), 16'($urandom_range(5, 1)),
                     8'($urandom_range(255, 1)));
      for (int k = 0; k < 60; k++) begin
        if (k % 20 == 0) quiet_stretch = ($urandom_range(2, 0) == 0);
        pick = $urandom_range(99, 0);
        if (pick < 50) begin
          send_event(OP_TICK, 2'($urandom), 8'($urandom), 16'($urandom));
        end else if (pick < 70) begin
          send_event(OP_MSG, KIND_CONN_REQ,
                     ($urandom_range(9, 0) < 7) ? 8'($urandom_range(15, 0)) : 8'($urandom),
                     16'($urandom));
        end else if (pick < 85) begin
          send_event(OP_MSG, KIND_TOKEN_OUT, 8'($urandom), 16'($urandom));
        end else if (pick < 90) begin
          send_event(OP_RESET, 2'($urandom), 8'($urandom), 16'($urandom));
        end else begin
          send_event(2'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  task automatic test_slave_rounds();
    int pick;
    logic [DIV_W-1:0] div;
    for (int chunk = 0; chunk < 4; chunk++) begin
      div = 8'($urandom_range(8, 1));
      apply_settings(1'b0, 16'($urandom_range(65535, 1)), 16'($urandom_range(6, 1)), div);
      for (int k = 0; k < 30; k++) begin
        if (k % 15 == 0) quiet_stretch = ($urandom_range(2, 0) == 0);
        pick = $urandom_range(99, 0);
        if (pick < 20) begin
          send_event(OP_MSG, KIND_ACCEPTING, 8'($urandom),
                     16'(div * $urandom_range(300, 0)));
        end else if (pick < 35) begin
          send_event(OP_MSG, KIND_ACCEPTING, 8'($urandom), 16'($urandom));
        end else if (pick < 55) begin
          send_event(OP_MSG, KIND_TOKEN_IN, 8'($urandom), 16'($urandom));
        end else if (pick < 85) begin
          send_event(OP_TICK, 2'($urandom), 8'($urandom), 16'($urandom));
        end else if (pick < 90) begin
          send_event(OP_RESET, 2'($urandom), 8'($urandom), 16'($urandom));
        end else begin
          send_event(2'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  task automatic test_role_swaps();
    for (int k = 0; k < 4; k++) begin
      apply_settings(k[0], 16'd2, 16'd2, 8'($urandom_range(255, 1)));
      repeat (15) send_event(2'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_backpressure();
    quiet_stretch = 1'b0;
    apply_settings(1'b1, 16'd2, 16'd3, 8'd7);
    sink_hold_req = 1'b1;
    for (int k = 0; k < 30; k++) begin
      send_event((k % 3 == 0) ? OP_MSG : OP_TICK, KIND_CONN_REQ, 8'(k), 16'($urandom));
    end
    wait_idle();
    for (int k = 0; k < 20; k++) begin
      send_event((k % 4 == 0) ? OP_MSG : OP_TICK, KIND_TOKEN_OUT, 8'($urandom),
                 16'($urandom));
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    reset_node();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_slave_directed();
    test_master_directed();
    test_register_extremes();
    test_master_rounds();
    test_slave_rounds();
    test_role_swaps();
    test_backpressure();
    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
